// ===== rtl/core/bcdadj_pkg.sv =====
package bcdadj_pkg;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int DIV_BITS    = 4;   // quotient bits resolved per divide stage

    localparam logic [2:0] OP_AAA = 3'd0;
    localparam logic [2:0] OP_AAS = 3'd1;
    localparam logic [2:0] OP_DAA = 3'd2;
    localparam logic [2:0] OP_DAS = 3'd3;
    localparam logic [2:0] OP_AAM = 3'd4;
    localparam logic [2:0] OP_AAD = 3'd5;

    localparam logic [5:0] WM_CF   = 6'h01;
    localparam logic [5:0] WM_AF   = 6'h02;
    localparam logic [5:0] WM_OF   = 6'h04;
    localparam logic [5:0] WM_ZF   = 6'h08;
    localparam logic [5:0] WM_SF   = 6'h10;
    localparam logic [5:0] WM_PF   = 6'h20;
    localparam logic [5:0] WM_ALL  = 6'h3F;
    localparam logic [5:0] WM_NONE = 6'h00;

    localparam logic [7:0] LO_NIBBLE = 8'h0F;
    localparam logic [7:0] AAA_CARRY = 8'hF9;
    localparam logic [7:0] DAA_LIMIT = 8'h99;
    localparam logic [7:0] HI_ADJ    = 8'h60;
    localparam logic [7:0] LO_ADJ    = 8'h06;
    localparam logic [3:0] NIB_MAX   = 4'd9;

    // decode stage result
    typedef struct packed {
        logic       is_aam;
        logic       is_aad;
        logic [7:0] al;
        logic [7:0] ah;
        logic [7:0] divisor;
        logic [7:0] res_al;
        logic [7:0] res_ah;
        logic       res_cf;
        logic       res_af;
        logic [5:0] mask;
    } s1_t;

    // after the upper half of the divide and the multiply
    typedef struct packed {
        logic       is_aam;
        logic       is_aad;
        logic [7:0] al;
        logic [7:0] divisor;
        logic [7:0] rem;
        logic [3:0] q_hi;
        logic [7:0] prod_lo;
        logic [7:0] res_al;
        logic [7:0] res_ah;
        logic       res_cf;
        logic       res_af;
        logic [5:0] mask;
    } s2_t;

    // final accumulator bytes before flag generation
    typedef struct packed {
        logic [7:0] al;
        logic [7:0] ah;
        logic       cf;
        logic       af;
        logic [5:0] mask;
    } s3_t;

endpackage

// ===== rtl/core/bcd_adjust_unit.sv =====
// An accepted input transaction passes the s1, s2, s3 and output registers on its way to m_tvalid.
// Throughput: one transaction per cycle while the pipeline is not stalled; the AAM divide is split over two
// stages of four quotient bits each, the AAD multiply runs beside the upper half
// and its add beside the lower half.
// s_tready drops only while the output register holds a result and m_tready is low.
// Reset (aresetn low, synchronous) clears every stage valid bit; data is not reset.
module bcd_adjust_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] al_in, [15:8] ah_in, [16] carry_in, [17] aux_in, [25:18] base, rest zero
    input  logic [31:0] s_tdata,
    // [2:0] operation
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] al_out, [15:8] ah_out, [16] carry_out, [17] aux_out, [18] overflow_out,
    // [19] zero_out, [20] sign_out, [21] parity_out, [27:22] flag_write_mask, rest zero
    output logic [31:0] m_tdata
);
    import bcdadj_pkg::*;

    logic                   adv;
    s1_t                    s1_next;
    s1_t                    s1_reg;
    s2_t                    s2_next;
    s2_t                    s2_reg;
    s3_t                    s3_next;
    s3_t                    s3_reg;
    logic                   v1_reg;
    logic                   v2_reg;
    logic                   v3_reg;
    logic                   vo_reg;
    logic [OUT_TDATA_W-1:0] out_next;
    logic [OUT_TDATA_W-1:0] out_reg;
    logic [15:0]            prod;
    logic [7:0]             rem_hi;
    logic [3:0]             q_hi;
    logic [7:0]             rem_lo;
    logic [3:0]             q_lo;

    // whole pipeline moves together; a stall freezes every stage
    assign adv      = !vo_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vo_reg;
    assign m_tdata  = out_reg;

    bcdadj_adjust u_adjust (
        .op   (s_tuser),
        .al   (s_tdata[7:0]),
        .ah   (s_tdata[15:8]),
        .cf   (s_tdata[16]),
        .af   (s_tdata[17]),
        .base (s_tdata[25:18]),
        .s1   (s1_next)
    );

    bcdadj_div_step u_div_hi (
        .rem_in   (8'd0),
        .num_bits (s1_reg.al[7:4]),
        .divisor  (s1_reg.divisor),
        .rem_out  (rem_hi),
        .q_bits   (q_hi)
    );

    always_comb begin
        prod            = {8'd0, s1_reg.ah} * {8'd0, s1_reg.divisor};
        s2_next.is_aam  = s1_reg.is_aam;
        s2_next.is_aad  = s1_reg.is_aad;
        s2_next.al      = s1_reg.al;
        s2_next.divisor = s1_reg.divisor;
        s2_next.rem     = rem_hi;
        s2_next.q_hi    = q_hi;
        s2_next.prod_lo = prod[7:0];
        s2_next.res_al  = s1_reg.res_al;
        s2_next.res_ah  = s1_reg.res_ah;
        s2_next.res_cf  = s1_reg.res_cf;
        s2_next.res_af  = s1_reg.res_af;
        s2_next.mask    = s1_reg.mask;
    end

    bcdadj_div_step u_div_lo (
        .rem_in   (s2_reg.rem),
        .num_bits (s2_reg.al[3:0]),
        .divisor  (s2_reg.divisor),
        .rem_out  (rem_lo),
        .q_bits   (q_lo)
    );

    always_comb begin
        s3_next.cf   = s2_reg.res_cf;
        s3_next.af   = s2_reg.res_af;
        s3_next.mask = s2_reg.mask;
        if (s2_reg.is_aam) begin
            s3_next.al = rem_lo;
            s3_next.ah = {s2_reg.q_hi, q_lo};
        end else if (s2_reg.is_aad) begin
            // wraps to 8 bits
            s3_next.al = s2_reg.prod_lo + s2_reg.al;
            s3_next.ah = 8'd0;
        end else begin
            s3_next.al = s2_reg.res_al;
            s3_next.ah = s2_reg.res_ah;
        end
    end

    bcdadj_flags u_flags (
        .s3    (s3_reg),
        .tdata (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            out_reg <= out_next;
        end
    end

endmodule

// ===== rtl/core/bcdadj_adjust.sv =====
module bcdadj_adjust (
    input  logic [2:0]        op,
    input  logic [7:0]        al,
    input  logic [7:0]        ah,
    input  logic              cf,
    input  logic              af,
    input  logic [7:0]        base,
    output bcdadj_pkg::s1_t   s1
);
    import bcdadj_pkg::*;

    logic       lo_adj;
    logic       hi_adj;
    logic       sub;
    logic       icarry;
    logic [7:0] step;
    logic [7:0] v_lo;
    logic [7:0] v_hi;

    always_comb begin
        lo_adj = (al[3:0] > NIB_MAX) || af;
        hi_adj = (al > DAA_LIMIT) || cf;
        sub    = (op == OP_AAS) || (op == OP_DAS);
        icarry = sub ? (al < LO_ADJ) : (al > AAA_CARRY);
        step   = 8'd1 + {7'd0, icarry};
        v_lo   = lo_adj ? (sub ? al - LO_ADJ : al + LO_ADJ) : al;
        v_hi   = hi_adj ? (sub ? v_lo - HI_ADJ : v_lo + HI_ADJ) : v_lo;

        s1.is_aam  = (op == OP_AAM);
        s1.is_aad  = (op == OP_AAD);
        s1.al      = al;
        s1.ah      = ah;
        s1.divisor = (base == 8'd0) ? 8'd1 : base;
        s1.res_al  = al;
        s1.res_ah  = ah;
        s1.res_cf  = 1'b0;
        s1.res_af  = 1'b0;
        s1.mask    = WM_NONE;

        unique case (op)
            OP_AAA, OP_AAS: begin
                s1.res_al = v_lo & LO_NIBBLE;
                s1.res_ah = lo_adj ? (sub ? ah - step : ah + step) : ah;
                s1.res_cf = lo_adj;
                s1.res_af = lo_adj;
                s1.mask   = WM_CF | WM_AF;
            end
            OP_DAA, OP_DAS: begin
                s1.res_al = v_hi;
                // DAS also borrows out of the nibble correction
                s1.res_cf = hi_adj | (sub & lo_adj & ((al < LO_ADJ) | cf));
                s1.res_af = lo_adj;
                s1.mask   = WM_ALL;
            end
            OP_AAM, OP_AAD: begin
                s1.mask   = WM_ALL;
            end
            default: begin
                s1.mask   = WM_NONE;
            end
        endcase
    end

endmodule

// ===== rtl/core/bcdadj_div_step.sv =====
module bcdadj_div_step (
    input  logic [7:0]                      rem_in,
    input  logic [bcdadj_pkg::DIV_BITS-1:0] num_bits,
    input  logic [7:0]                      divisor,
    output logic [7:0]                      rem_out,
    output logic [bcdadj_pkg::DIV_BITS-1:0] q_bits
);
    import bcdadj_pkg::*;

    // restoring division, most significant dividend bit first
    always_comb begin
        logic [8:0] r;
        r = {1'b0, rem_in};
        for (int i = DIV_BITS - 1; i >= 0; i--) begin
            r = {r[7:0], num_bits[i]};
            if (r >= {1'b0, divisor}) begin
                r         = r - {1'b0, divisor};
                q_bits[i] = 1'b1;
            end else begin
                q_bits[i] = 1'b0;
            end
        end
        rem_out = r[7:0];
    end

endmodule

// ===== rtl/core/bcdadj_flags.sv =====
module bcdadj_flags (
    input  bcdadj_pkg::s3_t                    s3,
    output logic [bcdadj_pkg::OUT_TDATA_W-1:0] tdata
);
    import bcdadj_pkg::*;

    logic zf;
    logic sf;
    logic pf;
    logic cf;
    logic af;

    always_comb begin
        cf = s3.cf & s3.mask[0];
        af = s3.af & s3.mask[1];
        zf = (s3.al == 8'd0) & s3.mask[3];
        sf = s3.al[7] & s3.mask[4];
        pf = (~^s3.al) & s3.mask[5];
        tdata = '0;
        tdata[7:0]   = s3.al;
        tdata[15:8]  = s3.ah;
        tdata[16]    = cf;
        tdata[17]    = af;
        tdata[18]    = 1'b0;   // OF is always written as zero
        tdata[19]    = zf;
        tdata[20]    = sf;
        tdata[21]    = pf;
        tdata[27:22] = s3.mask;
    end

endmodule
